// File: rtl/tod_pkg.sv
// Types, field widths and hand-angle helpers for the time-of-day clock.
// Used by tod_core, the top level and the port checker; no dependencies.
package tod_pkg;

   localparam int REQ_TDATA_W = 8;
   localparam int RSP_TDATA_W = 48;

   localparam logic [4:0] HOUR_LAST   = 5'd23;
   localparam logic [5:0] MINSEC_LAST = 6'd59;
   localparam logic [4:0] RESET_HOUR  = 5'd12;
   localparam logic [8:0] ANGLE_BASE  = 9'd90;
   localparam logic [8:0] ANGLE_FULL  = 9'd360;

   localparam logic FUNC_TICK   = 1'b0;
   localparam logic FUNC_SAMPLE = 1'b1;

   typedef struct packed {
      logic       func;
      logic       hour_up;
      logic       hour_down;
      logic       minute_up;
      logic       minute_down;
      logic       raw_a;
      logic       raw_b;
      logic       raw_x;
      logic       raw_y;
   } req_type;

   typedef struct packed {
      logic [4:0] hour;
      logic [5:0] minute;
      logic [5:0] second;
      logic       twelve_hour;
      logic       left_held;
      logic       right_held;
      logic       stop;
   } tod_state_type;

   typedef struct packed {
      logic [4:0] shown_hour;
      logic [5:0] shown_minute;
      logic [5:0] shown_second;
      logic [8:0] hour_angle;
      logic [8:0] minute_angle;
      logic [8:0] second_angle;
      logic       twelve_hour_mode;
      logic       stopped;
   } rsp_type;

   // 90 + 6 * v, folded once into 0..359
   function automatic logic [8:0] angle_six(input logic [5:0] v);
      logic [8:0] a;
      a = ANGLE_BASE + 9'(v) * 9'd6;
      return (a >= ANGLE_FULL) ? a - ANGLE_FULL : a;
   endfunction

   // 90 + 30 * h for h in 0..11, folded once into 0..359
   function automatic logic [8:0] angle_thirty(input logic [3:0] h);
      logic [8:0] a;
      a = ANGLE_BASE + 9'(h) * 9'd30;
      return (a >= ANGLE_FULL) ? a - ANGLE_FULL : a;
   endfunction

endpackage

// File: rtl/tod_core.sv
// Next-state and display logic of the time-of-day clock for one request.
// Purely combinational; depends on tod_pkg.
module tod_core
   import tod_pkg::*;
(
   input  req_type       req,
   input  tod_state_type cur,
   output tod_state_type nxt,
   output rsp_type       rsp
);

   logic       hu, hd, mu, md, left_pair, right_pair;
   logic       min_carry, min_borrow;
   logic [5:0] minute_adj;
   logic [5:0] hour_sum;
   logic [4:0] hour_adj;
   logic [3:0] hour_half;

   assign hu         = req.hour_up & ~req.hour_down;
   assign hd         = req.hour_down & ~req.hour_up;
   assign mu         = req.minute_up & ~req.minute_down;
   assign md         = req.minute_down & ~req.minute_up;
   assign left_pair  = req.raw_a & req.raw_b;
   assign right_pair = req.raw_x & req.raw_y;

   // minute step with wrap into the hour
   always_comb begin
      min_carry  = 1'b0;
      min_borrow = 1'b0;
      minute_adj = cur.minute;
      if (mu) begin
         min_carry  = (cur.minute == MINSEC_LAST);
         minute_adj = min_carry ? 6'd0 : cur.minute + 6'd1;
      end else if (md) begin
         min_borrow = (cur.minute == 6'd0);
         minute_adj = min_borrow ? MINSEC_LAST : cur.minute - 6'd1;
      end
   end

   // hour moves by -2..+2, biased by 24 to stay positive
   assign hour_sum = 6'(cur.hour) + 6'd24 + 6'(hu) + 6'(min_carry)
                     - 6'(hd) - 6'(min_borrow);

   always_comb begin
      if (hour_sum >= 6'd48) begin
         hour_adj = 5'(hour_sum - 6'd48);
      end else if (hour_sum >= 6'd24) begin
         hour_adj = 5'(hour_sum - 6'd24);
      end else begin
         hour_adj = 5'(hour_sum);
      end
   end

   always_comb begin
      nxt = cur;
      if (req.func == FUNC_TICK) begin
         if (cur.second != MINSEC_LAST) begin
            nxt.second = cur.second + 6'd1;
         end else begin
            nxt.second = 6'd0;
            if (cur.minute != MINSEC_LAST) begin
               nxt.minute = cur.minute + 6'd1;
            end else begin
               nxt.minute = 6'd0;
               nxt.hour   = (cur.hour == HOUR_LAST) ? 5'd0 : cur.hour + 5'd1;
            end
         end
      end else begin
         nxt.minute = minute_adj;
         nxt.hour   = hour_adj;
         if (left_pair && right_pair) begin
            nxt.stop = 1'b1;
         end
         if (right_pair) begin
            if (!cur.right_held) begin
               nxt.second = 6'd0;
            end
            nxt.right_held = 1'b1;
         end else begin
            nxt.right_held = 1'b0;
         end
         if (left_pair) begin
            if (!cur.left_held) begin
               nxt.twelve_hour = ~cur.twelve_hour;
            end
            nxt.left_held = 1'b1;
         end else begin
            nxt.left_held = 1'b0;
         end
      end
   end

   assign hour_half = (nxt.hour >= 5'd12) ? 4'(nxt.hour - 5'd12) : 4'(nxt.hour);

   always_comb begin
      rsp.shown_hour       = nxt.hour;
      if (nxt.twelve_hour) begin
         rsp.shown_hour = (hour_half == 4'd0) ? 5'd12 : 5'(hour_half);
      end
      rsp.shown_minute     = nxt.minute;
      rsp.shown_second     = nxt.second;
      rsp.hour_angle       = angle_thirty(hour_half);
      rsp.minute_angle     = angle_six(nxt.minute);
      rsp.second_angle     = angle_six(nxt.second);
      rsp.twelve_hour_mode = nxt.twelve_hour;
      rsp.stopped          = nxt.stop;
   end

endmodule

// File: rtl/time_of_day_clock_with_set_buttons_top.sv
// Time-of-day clock with set buttons: request register, tod_core, result register.
// Depends on tod_pkg and tod_core.
//
// Accepts one request per clock while the response side is not stalled; each
// request yields one response through the request register, then the result
// register. The time update in tod_core is combinational and sits between the two.
// Time starts at 12:00:00 after reset, 24-hour display, stop flag clear.
module time_of_day_clock_with_set_buttons_top
   import tod_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // [0] hour_up [1] hour_down [2] minute_up [3] minute_down
   // [4] raw_a [5] raw_b [6] raw_x [7] raw_y
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   // [0] func
   input  logic                   req_tuser,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // [4:0] shown_hour [10:5] shown_minute [16:11] shown_second
   // [25:17] hour_angle [34:26] minute_angle [43:35] second_angle
   // [44] twelve_hour_mode [45] stopped [47:46] zero
   output logic [RSP_TDATA_W-1:0] rsp_tdata
);

   logic          in_vld_ff, in_vld_in;
   logic          rsp_vld_ff, rsp_vld_in;
   req_type       req_ff;
   tod_state_type state_ff, state_in;
   rsp_type       rsp_ff, rsp_in;
   logic          advance;

   assign advance    = in_vld_ff & (~rsp_vld_ff | rsp_tready);
   assign req_tready = ~in_vld_ff | advance;
   assign in_vld_in  = (req_tvalid & req_tready) | (in_vld_ff & ~advance);
   assign rsp_vld_in = advance | (rsp_vld_ff & ~rsp_tready);

   tod_core u_core (
      .req (req_ff),
      .cur (state_ff),
      .nxt (state_in),
      .rsp (rsp_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
         state_ff   <= '{hour: RESET_HOUR, minute: 6'd0, second: 6'd0,
                         twelve_hour: 1'b0, left_held: 1'b0, right_held: 1'b0,
                         stop: 1'b0};
      end else begin
         in_vld_ff  <= in_vld_in;
         rsp_vld_ff <= rsp_vld_in;
         if (advance) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         req_ff <= '{func: req_tuser, hour_up: req_tdata[0], hour_down: req_tdata[1],
                     minute_up: req_tdata[2], minute_down: req_tdata[3],
                     raw_a: req_tdata[4], raw_b: req_tdata[5], raw_x: req_tdata[6],
                     raw_y: req_tdata[7]};
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {2'b00, rsp_ff.stopped, rsp_ff.twelve_hour_mode,
                        rsp_ff.second_angle, rsp_ff.minute_angle, rsp_ff.hour_angle,
                        rsp_ff.shown_second, rsp_ff.shown_minute, rsp_ff.shown_hour};

endmodule

// File: rtl/tod_checker.sv
// Port-level checks for the time-of-day clock top, bound to it below.
// Depends on tod_pkg.
module tod_port_checker
   import tod_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [RSP_TDATA_W-1:0] rsp_tdata
);

   logic stop_seen_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         stop_seen_ff <= 1'b0;
      end else if (rsp_tvalid && rsp_tready && rsp_tdata[45]) begin
         stop_seen_ff <= 1'b1;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");

   a_stop_sticky: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && stop_seen_ff |-> rsp_tdata[45])
      else $error("stop flag cleared");

   a_ranges: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[4:0] <= 5'd23 && rsp_tdata[10:5] <= 6'd59
         && rsp_tdata[16:11] <= 6'd59 && rsp_tdata[25:17] < 9'd360
         && rsp_tdata[34:26] < 9'd360 && rsp_tdata[43:35] < 9'd360
         && rsp_tdata[47:46] == 2'b00)
      else $error("response field out of range");

   a_twelve_hour: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[44] |-> rsp_tdata[4:0] >= 5'd1 && rsp_tdata[4:0] <= 5'd12)
      else $error("twelve-hour display out of 1..12");

   a_second_hand: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[43:35] == angle_six(rsp_tdata[16:11]))
      else $error("second hand angle mismatch");

endmodule

bind time_of_day_clock_with_set_buttons_top tod_port_checker u_tod_port_checker (.*);

// File: dv/tod_checker.sv
`timescale 1ns / 1ps
// Response checker for the time-of-day clock: tracks accepted requests and predicts each response.
// Compares every response with the oldest prediction. Depends on tod_pkg.
module tod_checker
   import tod_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   input  logic                   req_tuser,
   input  logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  logic [RSP_TDATA_W-1:0] rsp_tdata,
   output int                     mismatches,
   output int                     awaited,
   output int                     checked
);

   localparam int DAY_SECS  = 86400;
   localparam int HOUR_SECS = 3600;
   localparam int MIN_SECS  = 60;
   localparam int NOON_SECS = 43200;

   int   sec_of_day;
   logic twelve_on;
   logic left_held;
   logic right_held;
   logic stop_seen;

   rsp_type time_q[$];
   rsp_type got;
   rsp_type want;

   function automatic req_type unpack_req(input logic [REQ_TDATA_W-1:0] d, input logic user);
      req_type rq;
      rq.func        = user;
      rq.hour_up     = d[0];
      rq.hour_down   = d[1];
      rq.minute_up   = d[2];
      rq.minute_down = d[3];
      rq.raw_a       = d[4];
      rq.raw_b       = d[5];
      rq.raw_x       = d[6];
      rq.raw_y       = d[7];
      return rq;
   endfunction

   function automatic rsp_type unpack_rsp(input logic [RSP_TDATA_W-1:0] d);
      rsp_type r;
      r.shown_hour       = d[4:0];
      r.shown_minute     = d[10:5];
      r.shown_second     = d[16:11];
      r.hour_angle       = d[25:17];
      r.minute_angle     = d[34:26];
      r.second_angle     = d[43:35];
      r.twelve_hour_mode = d[44];
      r.stopped          = d[45];
      return r;
   endfunction

   // updates the clock state for one request and returns the time shown afterwards
   function automatic rsp_type advance_clock(input req_type rq);
      rsp_type r;
      int      s;
      int      hr;
      int      mn;
      int      sc;
      logic    left;
      logic    right;
      s = sec_of_day;
      if (rq.func == FUNC_TICK) begin
         s = (s + 1) % DAY_SECS;
      end else begin
         if (rq.minute_down && !rq.minute_up) s = (s + DAY_SECS - MIN_SECS) % DAY_SECS;
         if (rq.hour_up && !rq.hour_down) s = (s + HOUR_SECS) % DAY_SECS;
         if (rq.hour_down && !rq.hour_up) s = (s + DAY_SECS - HOUR_SECS) % DAY_SECS;
         if (rq.minute_up && !rq.minute_down) s = (s + MIN_SECS) % DAY_SECS;
         left  = rq.raw_a && rq.raw_b;
         right = rq.raw_x && rq.raw_y;
         if (left && right) stop_seen = 1'b1;
         if (right) begin
            if (!right_held) begin
               s = s - (s % MIN_SECS);
               right_held = 1'b1;
            end
         end else begin
            right_held = 1'b0;
         end
         if (left) begin
            if (!left_held) begin
               twelve_on = !twelve_on;
               left_held = 1'b1;
            end
         end else begin
            left_held = 1'b0;
         end
      end
      sec_of_day = s;
      hr = s / HOUR_SECS;
      mn = (s % HOUR_SECS) / MIN_SECS;
      sc = s % MIN_SECS;
      if (twelve_on) begin
         hr = hr % 12;
         if (hr == 0) hr = 12;
      end
      r.shown_hour       = 5'(hr);
      r.shown_minute     = 6'(mn);
      r.shown_second     = 6'(sc);
      r.hour_angle       = 9'((90 + (hr % 12) * 30) % 360);
      r.minute_angle     = 9'((90 + mn * 6) % 360);
      r.second_angle     = 9'((90 + sc * 6) % 360);
      r.twelve_hour_mode = twelve_on;
      r.stopped          = stop_seen;
      return r;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         sec_of_day = NOON_SECS;
         twelve_on  = 1'b0;
         left_held  = 1'b0;
         right_held = 1'b0;
         stop_seen  = 1'b0;
         mismatches = 0;
         checked    = 0;
         time_q.delete();
      end else begin
         if (req_tvalid && req_tready)
            time_q.push_back(advance_clock(unpack_req(req_tdata, req_tuser)));
         if (rsp_tvalid && rsp_tready) begin
            got = unpack_rsp(rsp_tdata);
            if (time_q.size() == 0) begin
               if (mismatches < 10)
                  $display("%0t: response with no request outstanding: tdata=%h",
                           $realtime, rsp_tdata);
               mismatches++;
            end else begin
               want = time_q.pop_front();
               checked++;
               if (got.shown_hour !== want.shown_hour ||
                   got.shown_minute !== want.shown_minute ||
                   got.shown_second !== want.shown_second ||
                   got.hour_angle !== want.hour_angle ||
                   got.minute_angle !== want.minute_angle ||
                   got.second_angle !== want.second_angle ||
                   got.twelve_hour_mode !== want.twelve_hour_mode ||
                   got.stopped !== want.stopped) begin
                  if (mismatches < 10) begin
                     $display("%0t: response %0d mismatch", $realtime, checked);
                     $display("  expected %0d:%0d:%0d angles %0d/%0d/%0d 12h=%b stop=%b",
                              want.shown_hour, want.shown_minute, want.shown_second,
                              want.hour_angle, want.minute_angle, want.second_angle,
                              want.twelve_hour_mode, want.stopped);
                     $display("  actual   %0d:%0d:%0d angles %0d/%0d/%0d 12h=%b stop=%b",
                              got.shown_hour, got.shown_minute, got.shown_second,
                              got.hour_angle, got.minute_angle, got.second_angle,
                              got.twelve_hour_mode, got.stopped);
                  end
                  mismatches++;
               end
            end
         end
      end
      awaited <= time_q.size();
   end

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 1ps
// Top of the time-of-day clock testbench: clock, reset, request stimulus and verdict.
// Depends on tod_pkg, time_of_day_clock_with_set_buttons_top and tod_checker.
module tb_top;
   import tod_pkg::*;

   localparam int RANDOM_REQUESTS = 1460;
   localparam int DRAIN_POINT     = 500;
   localparam int CALM_FIRST      = 800;
   localparam int CALM_LAST       = 1100;
   localparam int QUIET_LIMIT     = 2000;
   localparam int TAIL_CYCLES     = 10;

   localparam logic [7:0] NO_BUTTON   = 8'h00;
   localparam logic [7:0] HOUR_UP     = 8'h01;
   localparam logic [7:0] HOUR_DOWN   = 8'h02;
   localparam logic [7:0] MINUTE_UP   = 8'h04;
   localparam logic [7:0] MINUTE_DOWN = 8'h08;
   localparam logic [7:0] RAW_A       = 8'h10;
   localparam logic [7:0] RAW_B       = 8'h20;
   localparam logic [7:0] RAW_X       = 8'h40;
   localparam logic [7:0] RAW_Y       = 8'h80;
   localparam logic [7:0] LEFT_PAIR   = RAW_A | RAW_B;
   localparam logic [7:0] RIGHT_PAIR  = RAW_X | RAW_Y;
   localparam logic [7:0] ALL_BUTTONS = 8'hFF;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic                   req_tuser  = FUNC_TICK;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;

   int   mismatches;
   int   awaited;
   int   checked;
   int   sent    = 0;
   int   ticks   = 0;
   int   samples = 0;
   int   quiet   = 0;
   logic calm    = 1'b0;

   always #4 clock = ~clock;

   time_of_day_clock_with_set_buttons_top DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   tod_checker u_tod_checker (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .mismatches (mismatches),
      .awaited    (awaited),
      .checked    (checked)
   );

   always @(posedge clock) begin
      rsp_tready <= calm || ($urandom_range(99) >= 7);
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet <= 0;
      end else if (quiet >= QUIET_LIMIT) begin
         $display("time_of_day_clock_with_set_buttons_top verification failed");
         $finish;
      end else begin
         quiet <= quiet + 1;
      end
   end

   task automatic send_request(input logic func, input logic [7:0] buttons);
      while (!calm && $urandom_range(99) < 7) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= func;
      req_tdata  <= buttons;
      do @(posedge clock); while (!req_tready);
      sent++;
      if (func == FUNC_TICK) ticks++;
      else samples++;
      calm <= (sent >= CALM_FIRST && sent < CALM_LAST);
   endtask

   // qualified buttons pressed now and then, raw pairs mostly pressed or released as pairs
   function automatic logic [7:0] random_buttons();
      logic [7:0] b;
      int         i;
      b = NO_BUTTON;
      for (i = 0; i < 4; i++) b[i] = ($urandom_range(3) == 0);
      case ($urandom_range(9))
         4, 5:    b = b | LEFT_PAIR;
         6, 7:    b = b | RIGHT_PAIR;
         8:       b = b | LEFT_PAIR | RIGHT_PAIR;
         9:       b[7:4] = 4'($urandom);
         default: ;
      endcase
      return b;
   endfunction

   initial begin
      int   last;
      int   burst;
      logic drained;
      drained = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      send_request(FUNC_TICK, NO_BUTTON);
      send_request(FUNC_SAMPLE, NO_BUTTON);
      send_request(FUNC_SAMPLE, HOUR_UP);
      send_request(FUNC_SAMPLE, HOUR_DOWN);
      send_request(FUNC_SAMPLE, HOUR_UP | HOUR_DOWN);
      send_request(FUNC_SAMPLE, MINUTE_UP);
      send_request(FUNC_SAMPLE, MINUTE_DOWN);
      send_request(FUNC_SAMPLE, MINUTE_UP | MINUTE_DOWN);
      send_request(FUNC_SAMPLE, RIGHT_PAIR);
      send_request(FUNC_TICK, ALL_BUTTONS);
      send_request(FUNC_SAMPLE, RIGHT_PAIR);
      send_request(FUNC_SAMPLE, LEFT_PAIR);
      send_request(FUNC_SAMPLE, LEFT_PAIR | HOUR_UP);
      send_request(FUNC_SAMPLE, RAW_A);
      send_request(FUNC_SAMPLE, LEFT_PAIR | RIGHT_PAIR);
      send_request(FUNC_SAMPLE, ALL_BUTTONS);
      send_request(FUNC_SAMPLE, NO_BUTTON);
      send_request(FUNC_SAMPLE, LEFT_PAIR);
      send_request(FUNC_SAMPLE, HOUR_DOWN | MINUTE_DOWN);
      send_request(FUNC_SAMPLE, HOUR_UP | MINUTE_UP);

      // walk to midnight in twelve-hour display, step back a minute, tick across midnight
      repeat (11) send_request(FUNC_SAMPLE, HOUR_UP);
      send_request(FUNC_SAMPLE, MINUTE_DOWN);
      repeat (60) send_request(FUNC_TICK, 8'($urandom));

      last = sent + RANDOM_REQUESTS;
      while (sent < last) begin
         if (!drained && sent >= DRAIN_POINT) begin
            req_tvalid <= 1'b0;
            do @(posedge clock); while (awaited != 0);
            drained = 1'b1;
         end
         case ($urandom_range(99)) inside
            [0:9]: begin
               burst = $urandom_range(30, 90);
               if (burst > last - sent) burst = last - sent;
               repeat (burst) send_request(FUNC_TICK, 8'($urandom));
            end
            [10:44]: send_request(FUNC_TICK, 8'($urandom));
            default: send_request(FUNC_SAMPLE, random_buttons());
         endcase
      end

      req_tvalid <= 1'b0;
      do @(posedge clock); while (awaited != 0);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Run: %0d requests (%0d ticks, %0d button samples), %0d responses compared",
               sent, ticks, samples, checked);
      $display("Covered midnight rollover, opposing buttons, pair edges and the stop flag");
      if (mismatches == 0 && awaited == 0) begin
         $display("time_of_day_clock_with_set_buttons_top verification clean");
      end else begin
         $display("time_of_day_clock_with_set_buttons_top verification failed");
      end
      $finish;
   end

endmodule

// File: files.f
rtl/tod_pkg.sv
rtl/tod_core.sv
rtl/time_of_day_clock_with_set_buttons_top.sv
rtl/tod_checker.sv
dv/tod_checker.sv
dv/tb_top.sv
